@@ src/gws_pkg.sv @@
// Shared types, constants and direction tables for the grid word search block.
// No dependencies; imported by every module of the block.
`default_nettype none

package gws_pkg;

    // Store geometry
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int MAX_WORD = 32;

    localparam int ROW_W    = 6;
    localparam int COL_W    = 6;
    localparam int GRID_AW  = ROW_W + COL_W;
    localparam int WORD_AW  = 5;
    localparam int LEN_W    = 6;
    localparam int CHAR_W   = 8;
    localparam int CNT_W    = 7;
    localparam int DIR_W    = 3;
    localparam int POS_W    = 8;

    localparam logic [DIR_W-1:0] DIR_FIRST = '0;
    localparam logic [DIR_W-1:0] DIR_LAST  = '1;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_IN_USE = 1'b0,
        CFG_COLS_IN_USE = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_WRITE_CELL = 2'd0,
        OP_WRITE_WORD = 2'd1,
        OP_QUERY      = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_FIRST_CMP,
        S_STEP,
        S_CMP
    } state_t;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic signed [1:0]       step_t;

    // Input word
    typedef struct packed {
        op_t                operation;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [CHAR_W-1:0]  letter;
        logic [WORD_AW-1:0] word_index;
        logic [LEN_W-1:0]   word_length;
    } item_t;

    // Result word
    typedef struct packed {
        logic             found;
        logic [DIR_W-1:0] direction;
    } result_t;

    // Store write request
    typedef struct packed {
        logic               grid_we;
        logic [GRID_AW-1:0] grid_waddr;
        logic               word_we;
        logic [WORD_AW-1:0] word_waddr;
        logic [CHAR_W-1:0]  wdata;
    } wr_req_t;

    // Store read request and registered read data
    typedef struct packed {
        logic [GRID_AW-1:0] grid_raddr;
        logic [WORD_AW-1:0] word_raddr;
    } rd_req_t;

    typedef struct packed {
        logic [CHAR_W-1:0] grid_q;
        logic [CHAR_W-1:0] word_q;
    } rd_data_t;

    // Row step per direction: NW N NE W E SW S SE
    function automatic step_t step_row(input logic [DIR_W-1:0] d);
        step_t s;
        case (d) inside
            3'd0, 3'd1, 3'd2: s = -2'sd1;
            3'd3, 3'd4:       s = 2'sd0;
            default:          s = 2'sd1;
        endcase
        return s;
    endfunction

    // Column step per direction
    function automatic step_t step_col(input logic [DIR_W-1:0] d);
        step_t s;
        case (d) inside
            3'd0, 3'd3, 3'd5: s = -2'sd1;
            3'd1, 3'd6:       s = 2'sd0;
            default:          s = 2'sd1;
        endcase
        return s;
    endfunction

    function automatic pos_t step_add(input pos_t p, input step_t s);
        return p + pos_t'({{(POS_W-2){s[1]}}, s});
    endfunction

    function automatic pos_t base_pos(input logic [ROW_W-1:0] b);
        return pos_t'({{(POS_W-ROW_W){1'b0}}, b});
    endfunction

endpackage

`default_nettype wire

@@ src/gws_store.sv @@
// Grid and word character stores: one write port and one registered read each.
// Depends on gws_pkg.
`default_nettype none

module gws_store
    import gws_pkg::*;
(
    input  wire logic     clk,
    input  wire wr_req_t  wr,
    input  wire rd_req_t  rd,
    output rd_data_t      rdata
);

    logic [CHAR_W-1:0] grid_mem_reg [MAX_ROWS*MAX_COLS];
    logic [CHAR_W-1:0] word_mem_reg [MAX_WORD];
    logic [CHAR_W-1:0] grid_q_reg;
    logic [CHAR_W-1:0] word_q_reg;

    // grid memory
    always_ff @(posedge clk)
    begin
        if (wr.grid_we)
        begin
            grid_mem_reg[wr.grid_waddr] <= wr.wdata;
        end
        grid_q_reg <= grid_mem_reg[rd.grid_raddr];
    end

    // word memory
    always_ff @(posedge clk)
    begin
        if (wr.word_we)
        begin
            word_mem_reg[wr.word_waddr] <= wr.wdata;
        end
        word_q_reg <= word_mem_reg[rd.word_raddr];
    end

    assign rdata.grid_q = grid_q_reg;
    assign rdata.word_q = word_q_reg;

endmodule

`default_nettype wire

@@ src/gws_seq.sv @@
// Query sequencer: walks the directions one character at a time through a
// single address stepper and byte comparator. Depends on gws_pkg.
`default_nettype none

module gws_seq
    import gws_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire item_t                item,
    input  wire logic [CNT_W-1:0]     rows_in_use,
    input  wire logic [CNT_W-1:0]     cols_in_use,
    input  wire rd_data_t             rdata,
    output logic                      busy,
    output logic                      done,
    output result_t                   result,
    output wr_req_t                   wr,
    output rd_req_t                   rd
);

    state_t              state_reg,  state_next;
    logic [ROW_W-1:0]    r0_reg,     r0_next;
    logic [COL_W-1:0]    c0_reg,     c0_next;
    logic [LEN_W-1:0]    len_reg,    len_next;
    logic [CNT_W-1:0]    nr_reg,     nr_next;
    logic [CNT_W-1:0]    nc_reg,     nc_next;
    logic [DIR_W-1:0]    dir_reg,    dir_next;
    pos_t                pr_reg,     pr_next;
    pos_t                pc_reg,     pc_next;
    logic [WORD_AW-1:0]  k_reg,      k_next;
    logic                done_reg,   done_next;
    result_t             result_reg, result_next;

    logic                accept;
    logic [CNT_W-1:0]    nr_in;
    logic [CNT_W-1:0]    nc_in;
    logic [LEN_W-1:0]    len_in;
    logic                off_grid;
    logic                out_of_bounds;
    logic                char_eq;
    logic                last_char;
    logic                next_dir;
    logic [DIR_W-1:0]    dir_new;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    // clamp the bounds and the word length of an incoming query
    assign nr_in  = (rows_in_use > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : rows_in_use;
    assign nc_in  = (cols_in_use > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : cols_in_use;
    assign len_in = (item.word_length > LEN_W'(MAX_WORD)) ? LEN_W'(MAX_WORD)
                                                          : item.word_length;
    assign off_grid = ({1'b0, item.row} >= nr_in) || ({1'b0, item.col} >= nc_in);

    // shared bounds check and comparator
    assign out_of_bounds = (pr_reg < 0) || (pc_reg < 0)
                        || (pr_reg >= $signed({1'b0, nr_reg}))
                        || (pc_reg >= $signed({1'b0, nc_reg}));
    assign char_eq   = (rdata.grid_q == rdata.word_q);
    assign last_char = ({1'b0, k_reg} == (len_reg - LEN_W'(1)));

    // store ports: writes come straight from an accepted word
    always_comb
    begin
        wr.grid_we    = accept && (item.operation == OP_WRITE_CELL);
        wr.grid_waddr = {item.row, item.col};
        wr.word_we    = accept && (item.operation == OP_WRITE_WORD);
        wr.word_waddr = item.word_index;
        wr.wdata      = item.letter;

        if (state_reg == S_FIRST)
        begin
            rd.grid_raddr = {r0_reg, c0_reg};
            rd.word_raddr = '0;
        end
        else
        begin
            rd.grid_raddr = {pr_reg[ROW_W-1:0], pc_reg[COL_W-1:0]};
            rd.word_raddr = k_reg;
        end
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    // walk context
    always_ff @(posedge clk)
    begin
        r0_reg  <= r0_next;
        c0_reg  <= c0_next;
        len_reg <= len_next;
        nr_reg  <= nr_next;
        nc_reg  <= nc_next;
        dir_reg <= dir_next;
        pr_reg  <= pr_next;
        pc_reg  <= pc_next;
        k_reg   <= k_next;
    end

    // next state and datapath control
    always_comb
    begin
        state_next  = state_reg;
        r0_next     = r0_reg;
        c0_next     = c0_reg;
        len_next    = len_reg;
        nr_next     = nr_reg;
        nc_next     = nc_reg;
        dir_next    = dir_reg;
        pr_next     = pr_reg;
        pc_next     = pc_reg;
        k_next      = k_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        next_dir    = 1'b0;
        dir_new     = dir_reg + DIR_W'(1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    r0_next  = item.row;
                    c0_next  = item.col;
                    len_next = len_in;
                    nr_next  = nr_in;
                    nc_next  = nc_in;
                    unique case (item.operation)
                        OP_QUERY:
                        begin
                            if ((item.word_length == '0) || off_grid)
                            begin
                                done_next   = 1'b1;
                                result_next = '0;
                            end
                            else
                            begin
                                state_next = S_FIRST;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            result_next = '0;
                        end
                    endcase
                end
            end

            S_FIRST:
            begin
                state_next = S_FIRST_CMP;
            end

            S_FIRST_CMP:
            begin
                if (!char_eq)
                begin
                    state_next  = S_IDLE;
                    done_next   = 1'b1;
                    result_next = '0;
                end
                else if (len_reg == LEN_W'(1))
                begin
                    state_next            = S_IDLE;
                    done_next             = 1'b1;
                    result_next.found     = 1'b1;
                    result_next.direction = DIR_FIRST;
                end
                else
                begin
                    next_dir = 1'b1;
                    dir_new  = DIR_FIRST;
                end
            end

            S_STEP:
            begin
                if (out_of_bounds)
                begin
                    next_dir = 1'b1;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end

            S_CMP:
            begin
                if (!char_eq)
                begin
                    next_dir = 1'b1;
                end
                else if (last_char)
                begin
                    state_next            = S_IDLE;
                    done_next             = 1'b1;
                    result_next.found     = 1'b1;
                    result_next.direction = dir_reg;
                end
                else
                begin
                    k_next     = k_reg + WORD_AW'(1);
                    pr_next    = step_add(pr_reg, step_row(dir_reg));
                    pc_next    = step_add(pc_reg, step_col(dir_reg));
                    state_next = S_STEP;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // move to the next direction, or give up after the last one
        if (next_dir)
        begin
            if ((state_reg != S_FIRST_CMP) && (dir_reg == DIR_LAST))
            begin
                state_next  = S_IDLE;
                done_next   = 1'b1;
                result_next = '0;
            end
            else
            begin
                dir_next   = dir_new;
                pr_next    = step_add(base_pos(r0_reg), step_row(dir_new));
                pc_next    = step_add(base_pos(c0_reg), step_col(dir_new));
                k_next     = WORD_AW'(1);
                state_next = S_STEP;
            end
        end
    end

    // checks
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while a walk is still running");

    a_miss_dir_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !result_reg.found) |-> (result_reg.direction == '0))
        else $error("miss reported with nonzero direction");

    a_k_in_word: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (({1'b0, k_reg} < len_reg) && (k_reg != '0)))
        else $error("character index outside the word");

    a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.operation != OP_QUERY)) |=> (done_reg && !result_reg.found))
        else $error("write word did not give its result next cycle");

    a_cmp_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> ($past(state_reg) == S_STEP))
        else $error("compare without a bounded read");

endmodule

`default_nettype wire

@@ src/grid_word_search_eight_dir_top.sv @@
// Top level of the eight-direction grid word search: configuration registers,
// query sequencer and character stores. Depends on gws_pkg, gws_seq, gws_store.
//
// Usage:
//   Input: drive item and raise start; the word is taken at a clock edge where
//   start is high and busy is low. Operations write one grid cell, write one
//   word character, or query a start cell with a word length.
//   Output: one result word per input word, shown on result for exactly one
//   cycle while done is high. The receiver cannot stall; it must take it then.
//   Configuration: cfg_we with cfg_index (0 rows in use, 1 columns in use) and
//   cfg_data; written at the edge. User must write only while idle (unchecked).
// Timing:
//   Writes and rejected queries: result in the next cycle, busy stays low, so
//   one write per cycle. A query holds busy while the sequencer walks: it reads
//   and compares the start character, then per direction steps and compares one
//   character at a time; a mismatch or leaving the grid ends a direction.
//   Busy time depends on L, word_length capped at 32; the single grid read port
//   and comparator set it. done rises at the edge where busy falls, so the
//   result shows in the first cycle with busy low.
// Reset: clears the sequencer and sets both bounds to 64. Store contents are
//   undefined until written.
`default_nettype none

module grid_word_search_eight_dir_top
    import gws_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire item_t                 item,
    output logic                       busy,
    output logic                       done,
    output result_t                    result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CNT_W-1:0] rows_in_use_reg;
    logic [CNT_W-1:0] cols_in_use_reg;
    wr_req_t          wr;
    rd_req_t          rd;
    rd_data_t         rdata;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg <= CNT_W'(MAX_ROWS);
            cols_in_use_reg <= CNT_W'(MAX_COLS);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ROWS_IN_USE: rows_in_use_reg <= cfg_data;
                CFG_COLS_IN_USE: cols_in_use_reg <= cfg_data;
                default:         rows_in_use_reg <= rows_in_use_reg;
            endcase
        end
    end

    gws_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .item        (item),
        .rows_in_use (rows_in_use_reg),
        .cols_in_use (cols_in_use_reg),
        .rdata       (rdata),
        .busy        (busy),
        .done        (done),
        .result      (result),
        .wr          (wr),
        .rd          (rd)
    );

    gws_store u_store (
        .clk   (clk),
        .wr    (wr),
        .rd    (rd),
        .rdata (rdata)
    );

endmodule

`default_nettype wire
